// ----- rtl/core/klsp_pkg.sv -----
// shared types and constants for the kernel log line stamp parser
package klsp_pkg;

   // byte codes the parser looks for
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FFEED   = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;

   // byte offset where the stamp starts
   localparam logic [12:0] STAMP_POS = 13'd3;

   localparam logic [39:0] SEC_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [29:0] NS_MAX  = 30'd999_999_999;
   localparam logic [30:0] NS_ONE  = 31'd1_000_000_000;

   // reciprocal of 125 for a 27 bit dividend, shift of 34 (ns / 1000 = (ns >> 3) / 125)
   localparam logic [27:0] RECIP_125 = 28'd137_438_954;
   localparam int          RECIP_SHIFT = 34;

   localparam int LEN_W = 13;
   localparam logic [LEN_W-1:0] LINE_MIN  = 13'd8;
   localparam logic [LEN_W-1:0] LINE_TOP  = 13'd8191;
   localparam logic [LEN_W-1:0] LINE_RST  = 13'd4096;

   // register indexes on the csr port
   localparam logic [1:0] CSR_KEEP_STAMP  = 2'd0;
   localparam logic [1:0] CSR_MAX_LINE    = 2'd1;
   localparam logic [1:0] CSR_OFFSET_SEC  = 2'd2;
   localparam logic [1:0] CSR_OFFSET_NSEC = 2'd3;

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_SPACE,
      PH_SECS,
      PH_FRAC,
      PH_DONE,
      PH_FAIL
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [12:0] line_length;
      logic        stamp_found;
      logic [12:0] strip_count;
      logic [39:0] real_seconds;
      logic [19:0] real_microseconds;
      logic        saturated;
   } rsp_type;

   // one closed line as the front hands it to the back
   typedef struct packed {
      logic [12:0] line_length;
      logic        found;
      logic [39:0] seconds;
      logic [29:0] fraction;
      logic [12:0] stamp_end;
      logic        overflow;
   } line_ev_type;

   typedef struct packed {
      logic        keep_stamp;
      logic [12:0] max_line;
      logic [39:0] offset_seconds;
      logic [29:0] offset_nanoseconds;
   } cfg_type;

   typedef struct packed {
      logic        found;
      logic [12:0] line_length;
      logic [12:0] strip_count;
      logic        overflow;
      logic [30:0] ns_sum;
      logic [40:0] sec_sum;
   } sum_stage_type;

   typedef struct packed {
      logic        found;
      logic [12:0] line_length;
      logic [12:0] strip_count;
      logic        saturated;
      logic [39:0] seconds;
      logic [29:0] ns_adj;
   } carry_stage_type;

   typedef struct packed {
      logic        found;
      logic [12:0] line_length;
      logic [12:0] strip_count;
      logic        saturated;
      logic [39:0] seconds;
      logic [54:0] product;
   } div_stage_type;

endpackage

// ----- rtl/core/kernel_log_line_stamp_parser_core.sv -----
// kernel log line splitter with stamp parser, top level
//
// req_*: one log byte per beat, or a flush beat that closes a pending partial line.
//   a beat is taken when req_push is high and req_full is low.
// rsp_*: one line descriptor per closed line, oldest first; valid while rsp_empty
//   is low, taken when rsp_pop is high.
// csr_*: 64 bit register port, registers at byte offsets 0, 8, 16, 24
//   (keep_stamp, max_line, offset_seconds, offset_nanoseconds); write only while idle.
// throughput: one byte per cycle while req_full is low. each beat is classified by the front
//   parser in the cycle it is taken; a closed line goes through a MID_DEPTH queue to a
//   three stage back pipeline (offset add, carry and saturate, reciprocal multiply).
// path: a closed line goes through the middle queue, the back stage registers and the output queue to rsp.
// stall: when rsp is not popped the output queue of OUT_DEPTH entries fills, the back
//   pipeline stops issuing, then the middle queue fills and req_full rises.
// reset: queues emptied, the open line dropped, registers back to their defaults.
module kernel_log_line_stamp_parser_core #(
   parameter int MAX_LINE  = 4096,
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  klsp_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output klsp_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int EV_W  = $bits(klsp_pkg::line_ev_type);
   localparam int RSP_W = $bits(klsp_pkg::rsp_type);
   localparam int MCW   = $clog2(MID_DEPTH + 1);
   localparam int OCW   = $clog2(OUT_DEPTH + 1);

   klsp_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  csr_wr;
   logic [1:0]            csr_idx;

   logic                  accept;
   logic                  ev_push, ev_pop, ev_full, ev_empty;
   klsp_pkg::line_ev_type ev_wdata, ev_rdata;
   logic [EV_W-1:0]       ev_rbits;
   logic [MCW-1:0]        ev_count;

   logic                  out_push, out_full;
   klsp_pkg::rsp_type     out_wdata;
   logic [RSP_W-1:0]      out_rbits;
   logic [OCW-1:0]        out_count;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:3];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            klsp_pkg::CSR_KEEP_STAMP:  cfg_in.keep_stamp         = csr_pwdata[0];
            klsp_pkg::CSR_MAX_LINE:    cfg_in.max_line           = csr_pwdata[12:0];
            klsp_pkg::CSR_OFFSET_SEC:  cfg_in.offset_seconds     = csr_pwdata[39:0];
            klsp_pkg::CSR_OFFSET_NSEC: cfg_in.offset_nanoseconds = csr_pwdata[29:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         klsp_pkg::CSR_KEEP_STAMP:  csr_prdata = 64'(cfg_ff.keep_stamp);
         klsp_pkg::CSR_MAX_LINE:    csr_prdata = 64'(cfg_ff.max_line);
         klsp_pkg::CSR_OFFSET_SEC:  csr_prdata = 64'(cfg_ff.offset_seconds);
         klsp_pkg::CSR_OFFSET_NSEC: csr_prdata = 64'(cfg_ff.offset_nanoseconds);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keep_stamp         <= 1'b0;
         cfg_ff.max_line           <= klsp_pkg::LINE_RST;
         cfg_ff.offset_seconds     <= '0;
         cfg_ff.offset_nanoseconds <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = ev_full;
   assign accept   = req_push && !req_full;

   klsp_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .max_line (cfg_ff.max_line),
      .ev_push  (ev_push),
      .ev_data  (ev_wdata)
   );

   klsp_fifo #(
      .WIDTH (EV_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (ev_push),
      .wdata (ev_wdata),
      .pop   (ev_pop),
      .rdata (ev_rbits),
      .full  (ev_full),
      .empty (ev_empty),
      .count (ev_count)
   );

   assign ev_rdata = klsp_pkg::line_ev_type'(ev_rbits);

   klsp_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ev_empty  (ev_empty || (ev_count == '0)),
      .ev_data   (ev_rdata),
      .ev_pop    (ev_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   klsp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .pop   (rsp_pop),
      .rdata (out_rbits),
      .full  (out_full),
      .empty (rsp_empty),
      .count (out_count)
   );

   assign rsp_data = out_full ? klsp_pkg::rsp_type'(out_rbits) : klsp_pkg::rsp_type'(out_rbits);

endmodule

// ----- rtl/core/klsp_fifo.sv -----
// small register queue with count, used between front and back and at the output
module klsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             wdata,
   input  logic                         pop,
   output logic [WIDTH-1:0]             rdata,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- rtl/core/klsp_front.sv -----
// front end: splits the byte stream into lines and parses the stamp as bytes arrive
module klsp_front #(
   parameter int MAX_LINE = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  klsp_pkg::req_type     req_data,
   input  logic [12:0]           max_line,
   output logic                  ev_push,
   output klsp_pkg::line_ev_type ev_data
);

   localparam int LIM_CAP = (MAX_LINE > 8191) ? 8191 : MAX_LINE;

   klsp_pkg::phase_type phase_ff, phase_in, phase_upd;
   logic [12:0] count_ff, count_in;
   logic [39:0] sec_ff, sec_in, sec_upd;
   logic [29:0] frac_ff, frac_in, frac_upd;
   logic [12:0] end_ff, end_in, end_upd;
   logic        ovf_ff, ovf_in, ovf_upd;

   logic [7:0]  b;
   logic [3:0]  digit;
   logic        is_digit, is_blank, is_flush, is_nl, is_byte, close;
   logic [43:0] sec_mul;
   logic [33:0] frac_mul;
   logic [12:0] lim, lim_m1, count_upd;

   assign b        = req_data.data_byte;
   assign digit    = 4'(b - klsp_pkg::CH_ZERO);
   assign is_digit = (b >= klsp_pkg::CH_ZERO) && (b <= klsp_pkg::CH_NINE);
   assign is_blank = (b == klsp_pkg::CH_SPACE) || (b == klsp_pkg::CH_TAB) ||
                     (b == klsp_pkg::CH_VTAB) || (b == klsp_pkg::CH_FFEED) ||
                     (b == klsp_pkg::CH_CR);
   assign is_flush = req_data.flush;
   assign is_nl    = !is_flush && (b == klsp_pkg::CH_NEWLINE);
   assign is_byte  = !is_flush && !is_nl;

   // acc * 10 + digit as two shifts and two adds
   assign sec_mul  = (44'(sec_ff) << 3) + (44'(sec_ff) << 1) + 44'(digit);
   assign frac_mul = (34'(frac_ff) << 3) + (34'(frac_ff) << 1) + 34'(digit);

   // line limit clamped to the supported range
   always_comb begin
      if (max_line < klsp_pkg::LINE_MIN) begin
         lim = klsp_pkg::LINE_MIN;
      end else if (max_line > 13'(LIM_CAP)) begin
         lim = 13'(LIM_CAP);
      end else begin
         lim = max_line;
      end
   end
   assign lim_m1    = lim - 13'd1;
   assign count_upd = count_ff + 13'd1;

   // stamp parser next phase for a line byte
   always_comb begin
      phase_upd = phase_ff;
      case (phase_ff)
         klsp_pkg::PH_PREFIX: begin
            if (count_ff == klsp_pkg::STAMP_POS) begin
               phase_upd = (b == klsp_pkg::CH_LBRACK) ? klsp_pkg::PH_SPACE : klsp_pkg::PH_FAIL;
            end
         end
         klsp_pkg::PH_SPACE: begin
            if (is_blank) begin
               phase_upd = klsp_pkg::PH_SPACE;
            end else if (is_digit) begin
               phase_upd = klsp_pkg::PH_SECS;
            end else begin
               phase_upd = (b == klsp_pkg::CH_DOT) ? klsp_pkg::PH_FRAC : klsp_pkg::PH_FAIL;
            end
         end
         klsp_pkg::PH_SECS: begin
            if (!is_digit) begin
               phase_upd = (b == klsp_pkg::CH_DOT) ? klsp_pkg::PH_FRAC : klsp_pkg::PH_FAIL;
            end
         end
         klsp_pkg::PH_FRAC: begin
            if (is_digit) begin
               phase_upd = klsp_pkg::PH_FRAC;
            end else if (b == klsp_pkg::CH_RBRACK) begin
               phase_upd = klsp_pkg::PH_DONE;
            end else begin
               phase_upd = klsp_pkg::PH_FAIL;
            end
         end
         default: phase_upd = phase_ff;
      endcase
   end

   // accumulator and stamp end updates for a line byte
   always_comb begin
      sec_upd  = sec_ff;
      frac_upd = frac_ff;
      end_upd  = end_ff;
      ovf_upd  = ovf_ff;
      case (phase_ff)
         klsp_pkg::PH_SPACE, klsp_pkg::PH_SECS: begin
            if (is_digit) begin
               if (sec_mul > 44'(klsp_pkg::SEC_MAX)) begin
                  sec_upd = klsp_pkg::SEC_MAX;
                  ovf_upd = 1'b1;
               end else begin
                  sec_upd = sec_mul[39:0];
               end
            end
         end
         klsp_pkg::PH_FRAC: begin
            if (is_digit) begin
               if (frac_mul > 34'(klsp_pkg::NS_MAX)) begin
                  frac_upd = klsp_pkg::NS_MAX;
                  ovf_upd  = 1'b1;
               end else begin
                  frac_upd = frac_mul[29:0];
               end
            end else if (b == klsp_pkg::CH_RBRACK) begin
               end_upd = count_upd;
            end
         end
         default: begin
            sec_upd = sec_ff;
         end
      endcase
   end

   // a line byte closes at one below the limit, newline always, flush only with pending bytes
   always_comb begin
      if (is_flush) begin
         close = (count_ff != '0);
      end else if (is_nl) begin
         close = 1'b1;
      end else begin
         close = (count_upd >= lim_m1);
      end
   end

   always_comb begin
      if (is_byte) begin
         ev_data.line_length = count_upd;
         ev_data.found       = (phase_upd == klsp_pkg::PH_DONE);
         ev_data.seconds     = sec_upd;
         ev_data.fraction    = frac_upd;
         ev_data.stamp_end   = end_upd;
         ev_data.overflow    = ovf_upd;
      end else begin
         ev_data.line_length = count_ff;
         ev_data.found       = (phase_ff == klsp_pkg::PH_DONE);
         ev_data.seconds     = sec_ff;
         ev_data.fraction    = frac_ff;
         ev_data.stamp_end   = end_ff;
         ev_data.overflow    = ovf_ff;
      end
   end
   assign ev_push = accept && close;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      sec_in   = sec_ff;
      frac_in  = frac_ff;
      end_in   = end_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (close) begin
            phase_in = klsp_pkg::PH_PREFIX;
            count_in = '0;
            sec_in   = '0;
            frac_in  = '0;
            end_in   = '0;
            ovf_in   = 1'b0;
         end else if (is_byte) begin
            phase_in = phase_upd;
            count_in = count_upd;
            sec_in   = sec_upd;
            frac_in  = frac_upd;
            end_in   = end_upd;
            ovf_in   = ovf_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= klsp_pkg::PH_PREFIX;
         count_ff <= '0;
         sec_ff   <= '0;
         frac_ff  <= '0;
         end_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sec_ff   <= sec_in;
         frac_ff  <= frac_in;
         end_ff   <= end_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ----- rtl/core/klsp_back.sv -----
// back end: adds the clock offset, carries nanoseconds and divides down to microseconds
module klsp_back #(
   parameter int OUT_DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  klsp_pkg::cfg_type             cfg,
   input  logic                          ev_empty,
   input  klsp_pkg::line_ev_type         ev_data,
   output logic                          ev_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                          out_push,
   output klsp_pkg::rsp_type             out_data
);

   localparam int CW = $clog2(OUT_DEPTH + 1);

   logic                      v1_ff, v2_ff, v3_ff;
   klsp_pkg::sum_stage_type   s1_ff, s1_in;
   klsp_pkg::carry_stage_type s2_ff, s2_in;
   klsp_pkg::div_stage_type   s3_ff, s3_in;

   logic [1:0]    inflight;
   logic [CW+1:0] credit_use;
   logic [29:0]   ons;
   logic          carry;
   logic [41:0]   sec_tot;

   // issue only when the output queue has room for everything in flight
   assign inflight   = 2'(v1_ff) + 2'(v2_ff) + 2'(v3_ff);
   assign credit_use = (CW+2)'(out_count) + (CW+2)'(inflight);
   assign ev_pop     = !ev_empty && (credit_use < (CW+2)'(OUT_DEPTH));

   assign ons = (cfg.offset_nanoseconds > klsp_pkg::NS_MAX) ?
                klsp_pkg::NS_MAX : cfg.offset_nanoseconds;

   always_comb begin
      s1_in.found       = ev_data.found;
      s1_in.line_length = ev_data.line_length;
      s1_in.overflow    = ev_data.overflow;
      s1_in.ns_sum      = 31'(ev_data.fraction) + 31'(ons);
      s1_in.sec_sum     = 41'(ev_data.seconds) + 41'(cfg.offset_seconds);
      if (ev_data.found && !cfg.keep_stamp) begin
         s1_in.strip_count = ev_data.stamp_end - klsp_pkg::STAMP_POS;
      end else begin
         s1_in.strip_count = '0;
      end
   end

   assign carry   = (s1_ff.ns_sum > 31'(klsp_pkg::NS_MAX));
   assign sec_tot = 42'(s1_ff.sec_sum) + 42'(carry);

   always_comb begin
      s2_in.found       = s1_ff.found;
      s2_in.line_length = s1_ff.line_length;
      s2_in.strip_count = s1_ff.strip_count;
      if (!s1_ff.found) begin
         s2_in.seconds   = '0;
         s2_in.ns_adj    = '0;
         s2_in.saturated = 1'b0;
      end else begin
         s2_in.ns_adj = carry ? 30'(s1_ff.ns_sum - klsp_pkg::NS_ONE) : s1_ff.ns_sum[29:0];
         if (sec_tot > 42'(klsp_pkg::SEC_MAX)) begin
            s2_in.seconds   = klsp_pkg::SEC_MAX;
            s2_in.saturated = 1'b1;
         end else begin
            s2_in.seconds   = sec_tot[39:0];
            s2_in.saturated = s1_ff.overflow;
         end
      end
   end

   always_comb begin
      s3_in.found       = s2_ff.found;
      s3_in.line_length = s2_ff.line_length;
      s3_in.strip_count = s2_ff.strip_count;
      s3_in.saturated   = s2_ff.saturated;
      s3_in.seconds     = s2_ff.seconds;
      s3_in.product     = 55'(s2_ff.ns_adj[29:3]) * 55'(klsp_pkg::RECIP_125);
   end

   always_comb begin
      out_push                   = v3_ff;
      out_data.line_length       = s3_ff.line_length;
      out_data.stamp_found       = s3_ff.found;
      out_data.strip_count       = s3_ff.strip_count;
      out_data.real_seconds      = s3_ff.seconds;
      out_data.real_microseconds = s3_ff.product[klsp_pkg::RECIP_SHIFT +: 20];
      out_data.saturated         = s3_ff.saturated;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= ev_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

endmodule

// ----- rtl/core/klsp_checker.sv -----
// port level checks for the parser core, bound to the top level
module klsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input klsp_pkg::req_type req_data,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input klsp_pkg::rsp_type rsp_data,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic [4:0]        csr_paddr,
   input logic [63:0]       csr_pwdata,
   input logic [63:0]       csr_prdata,
   input logic              csr_pready
);

   // reset leaves no result and room for input
   a_reset_clean: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting descriptor holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("descriptor changed while stalled");

   // a line without a stamp carries no time, strip or flag
   a_no_stamp_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.stamp_found |->
         rsp_data.real_seconds == '0 && rsp_data.real_microseconds == '0 &&
         rsp_data.strip_count == '0 && !rsp_data.saturated)
      else $error("stamp fields set on a line without a stamp");

   // seconds offset reads back what was written
   a_offset_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready &&
       csr_paddr[4:3] == klsp_pkg::CSR_OFFSET_SEC) ##1
      (csr_paddr[4:3] == klsp_pkg::CSR_OFFSET_SEC && !csr_pwrite) |->
         csr_prdata[39:0] == $past(csr_pwdata[39:0]))
      else $error("offset_seconds readback mismatch");

endmodule

bind kernel_log_line_stamp_parser_core klsp_checker u_klsp_checker (.*);

// ----- tb/tb.sv -----
// testbench for the kernel log line stamp parser: queued bytes in, checked line descriptors out
module tb;

   localparam int LINE_CAP = 4096;
   localparam int SETTLE_CYCLES = 12;
   localparam int SEGMENT_BYTES = 160;
   localparam int RUN_LIMIT = 8_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   klsp_pkg::req_type req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   klsp_pkg::rsp_type rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [4:0]        csr_paddr = '0;
   logic [63:0]       csr_pwdata = '0;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   kernel_log_line_stamp_parser_core dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   klsp_pkg::req_type byte_backlog[$];
   klsp_pkg::rsp_type line_expect[$];
   int          mismatches = 0;
   int          send_idle = 0;
   int          recv_idle = 0;

   // register shadow
   logic        cfg_keep = 1'b0;
   logic [12:0] cfg_max_line = klsp_pkg::LINE_RST;
   logic [39:0] cfg_osec = '0;
   logic [29:0] cfg_onsec = '0;

   // open line shadow
   int                  open_len = 0;
   klsp_pkg::phase_type scan_phase = klsp_pkg::PH_PREFIX;
   logic [63:0]         sec_acc = '0;
   logic [63:0]         frac_acc = '0;
   logic [12:0]         stamp_stop = '0;
   logic                ovf_seen = 1'b0;

   function automatic bit is_blank(logic [7:0] b);
      return b == klsp_pkg::CH_SPACE || b == klsp_pkg::CH_TAB || b == klsp_pkg::CH_VTAB ||
             b == klsp_pkg::CH_FFEED || b == klsp_pkg::CH_CR;
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= klsp_pkg::CH_ZERO && b <= klsp_pkg::CH_NINE;
   endfunction

   function automatic logic [63:0] add_digit(logic [63:0] acc, logic [7:0] b,
                                             logic [63:0] cap);
      logic [63:0] v;
      v = acc * 10 + 64'(b - klsp_pkg::CH_ZERO);
      if (acc > cap || v > cap) begin
         ovf_seen = 1'b1;
         return cap;
      end
      return v;
   endfunction

   function automatic void scan_stamp_byte(logic [7:0] b, int pos);
      case (scan_phase)
         klsp_pkg::PH_PREFIX: begin
            if (pos == klsp_pkg::STAMP_POS)
               scan_phase = (b == klsp_pkg::CH_LBRACK) ? klsp_pkg::PH_SPACE :
                                                        klsp_pkg::PH_FAIL;
         end
         klsp_pkg::PH_SPACE: begin
            if (is_digit(b)) begin
               sec_acc = add_digit(sec_acc, b, 64'(klsp_pkg::SEC_MAX));
               scan_phase = klsp_pkg::PH_SECS;
            end else if (!is_blank(b)) begin
               scan_phase = (b == klsp_pkg::CH_DOT) ? klsp_pkg::PH_FRAC : klsp_pkg::PH_FAIL;
            end
         end
         klsp_pkg::PH_SECS: begin
            if (is_digit(b))
               sec_acc = add_digit(sec_acc, b, 64'(klsp_pkg::SEC_MAX));
            else
               scan_phase = (b == klsp_pkg::CH_DOT) ? klsp_pkg::PH_FRAC : klsp_pkg::PH_FAIL;
         end
         klsp_pkg::PH_FRAC: begin
            if (is_digit(b)) begin
               frac_acc = add_digit(frac_acc, b, 64'(klsp_pkg::NS_MAX));
            end else if (b == klsp_pkg::CH_RBRACK) begin
               stamp_stop = 13'(pos + 1);
               scan_phase = klsp_pkg::PH_DONE;
            end else begin
               scan_phase = klsp_pkg::PH_FAIL;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void close_open_line();
      klsp_pkg::rsp_type d;
      logic [29:0]       ons;
      logic [30:0]       ns;
      logic [40:0]       secs;
      logic              sat;
      d = '0;
      d.line_length = 13'(open_len);
      if (scan_phase == klsp_pkg::PH_DONE) begin
         ons = (cfg_onsec > klsp_pkg::NS_MAX) ? klsp_pkg::NS_MAX : cfg_onsec;
         ns = 31'(frac_acc) + 31'(ons);
         secs = 41'(sec_acc) + 41'(cfg_osec);
         sat = ovf_seen;
         if (ns > 31'(klsp_pkg::NS_MAX)) begin
            ns = ns - klsp_pkg::NS_ONE;
            secs = secs + 41'd1;
         end
         if (secs > 41'(klsp_pkg::SEC_MAX)) begin
            secs = 41'(klsp_pkg::SEC_MAX);
            sat = 1'b1;
         end
         d.stamp_found = 1'b1;
         d.real_seconds = secs[39:0];
         d.real_microseconds = 20'(ns / 31'd1000);
         d.saturated = sat;
         d.strip_count = cfg_keep ? 13'd0 : stamp_stop - klsp_pkg::STAMP_POS;
      end
      line_expect.push_back(d);
      open_len = 0;
      scan_phase = klsp_pkg::PH_PREFIX;
      sec_acc = '0;
      frac_acc = '0;
      stamp_stop = '0;
      ovf_seen = 1'b0;
   endfunction

   function automatic void split_beat(klsp_pkg::req_type beat);
      int lim;
      lim = cfg_max_line;
      if (lim < 8) lim = 8;
      if (lim > LINE_CAP) lim = LINE_CAP;
      if (beat.flush) begin
         if (open_len > 0) close_open_line();
         return;
      end
      if (beat.data_byte == klsp_pkg::CH_NEWLINE) begin
         close_open_line();
         return;
      end
      scan_stamp_byte(beat.data_byte, open_len);
      open_len++;
      if (open_len >= lim - 1) close_open_line();
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_line(klsp_pkg::rsp_type got);
      klsp_pkg::rsp_type want;
      if (line_expect.size() == 0) begin
         report_mismatch("descriptor with none outstanding");
         return;
      end
      want = line_expect.pop_front();
      if (got.line_length !== want.line_length)
         report_mismatch($sformatf("line_length %0d, want %0d",
                                   got.line_length, want.line_length));
      if (got.stamp_found !== want.stamp_found)
         report_mismatch($sformatf("stamp_found %0b, want %0b",
                                   got.stamp_found, want.stamp_found));
      if (got.strip_count !== want.strip_count)
         report_mismatch($sformatf("strip_count %0d, want %0d",
                                   got.strip_count, want.strip_count));
      if (got.real_seconds !== want.real_seconds)
         report_mismatch($sformatf("real_seconds %0d, want %0d",
                                   got.real_seconds, want.real_seconds));
      if (got.real_microseconds !== want.real_microseconds)
         report_mismatch($sformatf("real_microseconds %0d, want %0d",
                                   got.real_microseconds, want.real_microseconds));
      if (got.saturated !== want.saturated)
         report_mismatch($sformatf("saturated %0b, want %0b",
                                   got.saturated, want.saturated));
   endtask

   // sender: one beat per edge at most, held while full
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) split_beat(req_data);
         if (!req_push || !req_full) begin
            if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               req_data <= byte_backlog.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_line(rsp_data);
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   function automatic void queue_byte(logic [7:0] b);
      klsp_pkg::req_type r;
      r.data_byte = b;
      r.flush = 1'b0;
      byte_backlog.push_back(r);
   endfunction

   function automatic void queue_flush();
      klsp_pkg::req_type r;
      r.data_byte = 8'($urandom_range(0, 255));
      r.flush = 1'b1;
      byte_backlog.push_back(r);
   endfunction

   function automatic void queue_text(string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 4))
         0: return klsp_pkg::CH_SPACE;
         1: return klsp_pkg::CH_TAB;
         2: return klsp_pkg::CH_VTAB;
         3: return klsp_pkg::CH_FFEED;
         default: return klsp_pkg::CH_CR;
      endcase
   endfunction

   // mostly well formed "<n>[ sss.fff] text" lines, some noise and broken stamps
   function automatic void queue_log_line();
      int n;
      int pick;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 20);
         repeat (n) queue_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) queue_flush();
         return;
      end
      if ($urandom_range(0, 9) < 8) begin
         queue_byte("<");
         queue_byte(8'("0" + $urandom_range(0, 7)));
         queue_byte(">");
      end else begin
         repeat ($urandom_range(0, 5)) queue_byte(8'($urandom_range(8'h0B, 8'hFF)));
      end
      queue_byte(($urandom_range(0, 9) != 0) ? klsp_pkg::CH_LBRACK :
                                               8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) queue_byte(pick_blank());
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 16) : $urandom_range(0, 6);
      repeat (n) queue_byte(8'($urandom_range(klsp_pkg::CH_ZERO, klsp_pkg::CH_NINE)));
      queue_byte(($urandom_range(0, 14) != 0) ? klsp_pkg::CH_DOT :
                                                8'($urandom_range(0, 255)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
      repeat (n) queue_byte(8'($urandom_range(klsp_pkg::CH_ZERO, klsp_pkg::CH_NINE)));
      queue_byte(($urandom_range(0, 9) != 0) ? klsp_pkg::CH_RBRACK :
                                               8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 12)) begin
         if ($urandom_range(0, 7) == 0)
            queue_byte(8'($urandom_range(0, 255)));
         else
            queue_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      pick = $urandom_range(0, 9);
      if (pick < 8)
         queue_byte(klsp_pkg::CH_NEWLINE);
      else if (pick == 8)
         queue_flush();
   endfunction

   task automatic csr_write(logic [1:0] index, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(logic keep, logic [12:0] maxl, logic [39:0] osec,
                             logic [29:0] onsec);
      csr_write(klsp_pkg::CSR_KEEP_STAMP, 64'(keep));
      csr_write(klsp_pkg::CSR_MAX_LINE, 64'(maxl));
      csr_write(klsp_pkg::CSR_OFFSET_SEC, 64'(osec));
      csr_write(klsp_pkg::CSR_OFFSET_NSEC, 64'(onsec));
      cfg_keep = keep;
      cfg_max_line = maxl;
      cfg_osec = osec;
      cfg_onsec = onsec;
   endtask

   // everything sent and every descriptor back, then let the pipeline settle
   task automatic wait_drained();
      do @(negedge clock);
      while (byte_backlog.size() != 0 || req_push || line_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle = 31;
      recv_idle = 76;

      // reset defaults: empty line, empty flush, short line, blanks, bare dot, zero byte
      queue_byte(klsp_pkg::CH_NEWLINE);
      queue_flush();
      queue_text("<6>");
      queue_flush();
      queue_text("<6>[ ");
      queue_byte(klsp_pkg::CH_TAB);
      queue_byte(klsp_pkg::CH_VTAB);
      queue_byte(klsp_pkg::CH_FFEED);
      queue_byte(klsp_pkg::CH_CR);
      queue_text("12.5]");
      queue_byte(klsp_pkg::CH_NEWLINE);
      queue_text("<6>[.]");
      queue_byte(klsp_pkg::CH_NEWLINE);
      queue_byte(8'hFF);
      queue_text("6>[0");
      queue_byte(8'h00);
      queue_byte(klsp_pkg::CH_NEWLINE);
      wait_drained();

      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0: set_config(1'b0, 13'd4096, 40'($urandom_range(0, 100000)),
                          30'($urandom_range(0, 999_999_999)));
            1: set_config(1'b1, 13'd8, klsp_pkg::SEC_MAX, klsp_pkg::NS_MAX);
            2: set_config(1'b0, 13'd3, 40'd0, 30'h3FFF_FFFF);
            3: set_config(1'b1, 13'd40, {8'($urandom), 32'($urandom)},
                          30'($urandom_range(0, 999_999_999)));
            4: set_config(1'b0, klsp_pkg::LINE_TOP, {8'($urandom), 32'($urandom)}, 30'd0);
            default: set_config(1'b0, 13'd24,
                                klsp_pkg::SEC_MAX - 40'($urandom_range(0, 1000)),
                                30'($urandom_range(0, 999_999_999)));
         endcase
         if (seg == 2) begin
            send_idle = 76;
            recv_idle = 31;
         end else if (seg == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         while (byte_backlog.size() < SEGMENT_BYTES) queue_log_line();
         // leave a long open line so the next limit lands below it
         if (seg == 0) begin
            queue_flush();
            repeat (20) queue_byte(8'($urandom_range(8'h20, 8'h7E)));
         end
         wait_drained();
      end

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #RUN_LIMIT;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/klsp_pkg.sv
rtl/core/klsp_fifo.sv
rtl/core/klsp_front.sv
rtl/core/klsp_back.sv
rtl/core/kernel_log_line_stamp_parser_core.sv
rtl/core/klsp_checker.sv
tb/tb.sv
